// ===== design/mpsm_pkg.sv =====
// Package for the multi-pattern string matcher.
// Holds sizes, item and status codes, and the structs passed between modules.
// No dependencies.
package mpsm_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int SYMBOL_BITS = 8;
    localparam int COUNT_BITS  = 16;
    localparam int TOTAL_BITS  = 32;

    // Item kinds.
    localparam logic [1:0] KIND_PATTERN = 2'd0;
    localparam logic [1:0] KIND_BUILD   = 2'd1;
    localparam logic [1:0] KIND_TEXT    = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NOBUILD = 2'd2;

    typedef struct packed {
        logic [1:0]             kind;
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   last;
    } item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] position_matches;
        logic [TOTAL_BITS-1:0] total_matches;
        logic                  text_end;
    } result_t;

endpackage

// ===== design/mpsm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/mpsm_ctrl.sv =====
// Sequencer for the matcher: trie insertion, breadth-first link build and text walk.
// Holds the node memories in mpsm_ram instances; uses mpsm_pkg.
module mpsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mpsm_pkg::item_t    item,
    input  logic               out_free,
    output logic               idle,
    output logic               done,
    output mpsm_pkg::result_t  result
);

    localparam int NB = mpsm_pkg::NODE_BITS;
    localparam int SB = mpsm_pkg::SYMBOL_BITS;
    localparam int CB = mpsm_pkg::COUNT_BITS;
    localparam int TB = mpsm_pkg::TOTAL_BITS;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_PSTART  = 5'd1;
    localparam logic [4:0] S_PFOUND  = 5'd2;
    localparam logic [4:0] S_PLINK   = 5'd3;
    localparam logic [4:0] S_PLAST   = 5'd4;
    localparam logic [4:0] S_PINC_W  = 5'd5;
    localparam logic [4:0] S_BROOT   = 5'd6;
    localparam logic [4:0] S_BRSIB_W = 5'd7;
    localparam logic [4:0] S_BDEQ    = 5'd8;
    localparam logic [4:0] S_BDEQ_W  = 5'd9;
    localparam logic [4:0] S_BU_W    = 5'd10;
    localparam logic [4:0] S_BCHILD  = 5'd11;
    localparam logic [4:0] S_BC_W    = 5'd12;
    localparam logic [4:0] S_BFR     = 5'd13;
    localparam logic [4:0] S_BCNT_W  = 5'd14;
    localparam logic [4:0] S_BFF_W   = 5'd15;
    localparam logic [4:0] S_BNEXT   = 5'd16;
    localparam logic [4:0] S_BNEXT_W = 5'd17;
    localparam logic [4:0] S_TFR     = 5'd18;
    localparam logic [4:0] S_TFW     = 5'd19;
    localparam logic [4:0] S_TCNT    = 5'd20;
    localparam logic [4:0] S_TC_W    = 5'd21;
    localparam logic [4:0] S_TSUM    = 5'd22;
    localparam logic [4:0] S_FC0     = 5'd23;
    localparam logic [4:0] S_FC_W    = 5'd24;
    localparam logic [4:0] S_FCCHK   = 5'd25;
    localparam logic [4:0] S_FCCMP   = 5'd26;
    localparam logic [4:0] S_DONE    = 5'd27;

    localparam logic [NB-1:0] ROOT = '0;
    localparam logic [NB:0]   MAX_USED = (NB+1)'(mpsm_pkg::MAX_NODES);

    logic [4:0]    state_reg, state_next, ret_reg, ret_next;
    logic [1:0]    kind_reg, kind_next;
    logic [SB-1:0] sym_reg, sym_next, fsym_reg, fsym_next;
    logic          last_reg, last_next;
    logic [NB-1:0] cur_reg, cur_next, root_fc_reg, root_fc_next;
    logic [NB-1:0] walk_reg, walk_next, prev_reg, prev_next, found_reg, found_next;
    logic [NB-1:0] fnode_reg, fnode_next, child_reg, child_next, fu_reg, fu_next;
    logic          empty_reg, empty_next, built_reg, built_next, dropped_reg, dropped_next;
    logic [NB:0]   used_reg, used_next, head_reg, head_next, tail_reg, tail_next;
    logic [TB-1:0] total_reg, total_next;
    logic [CB-1:0] ccnt_reg, ccnt_next, pos_reg, pos_next;
    logic [1:0]    status_reg, status_next;

    // Memory ports.
    logic          char_we, fc_we, sib_we, fail_we, cnt_we, q_we;
    logic [NB-1:0] char_wa, fc_wa, sib_wa, fail_wa, cnt_wa, q_wa;
    logic [NB-1:0] char_ra, fc_ra, sib_ra, fail_ra, cnt_ra, q_ra;
    logic [SB-1:0] char_wd, char_rd;
    logic [NB-1:0] fc_wd, fc_rd, sib_wd, sib_rd, fail_wd, fail_rd, q_wd, q_rd;
    logic [CB-1:0] cnt_wd, cnt_rd;

    logic [CB:0]   cnt_sum;
    logic [TB:0]   tot_sum;

    mpsm_ram #(.WIDTH(SB), .DEPTH(mpsm_pkg::MAX_NODES)) u_char (
        .clk(clk), .we(char_we), .waddr(char_wa), .wdata(char_wd), .raddr(char_ra),
        .rdata(char_rd));
    mpsm_ram #(.WIDTH(NB), .DEPTH(mpsm_pkg::MAX_NODES)) u_fc (
        .clk(clk), .we(fc_we), .waddr(fc_wa), .wdata(fc_wd), .raddr(fc_ra), .rdata(fc_rd));
    mpsm_ram #(.WIDTH(NB), .DEPTH(mpsm_pkg::MAX_NODES)) u_sib (
        .clk(clk), .we(sib_we), .waddr(sib_wa), .wdata(sib_wd), .raddr(sib_ra),
        .rdata(sib_rd));
    mpsm_ram #(.WIDTH(NB), .DEPTH(mpsm_pkg::MAX_NODES)) u_fail (
        .clk(clk), .we(fail_we), .waddr(fail_wa), .wdata(fail_wd), .raddr(fail_ra),
        .rdata(fail_rd));
    mpsm_ram #(.WIDTH(CB), .DEPTH(mpsm_pkg::MAX_NODES)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra),
        .rdata(cnt_rd));
    mpsm_ram #(.WIDTH(NB), .DEPTH(mpsm_pkg::MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        result.status           = status_reg;
        result.position_matches = pos_reg;
        result.total_matches    = total_reg;
        result.text_end         = (kind_reg == mpsm_pkg::KIND_TEXT) && last_reg;
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;   ret_next = ret_reg;     kind_next = kind_reg;
        sym_next = sym_reg;       fsym_next = fsym_reg;   last_next = last_reg;
        cur_next = cur_reg;       root_fc_next = root_fc_reg;
        walk_next = walk_reg;     prev_next = prev_reg;   found_next = found_reg;
        fnode_next = fnode_reg;   child_next = child_reg; fu_next = fu_reg;
        empty_next = empty_reg;   built_next = built_reg; dropped_next = dropped_reg;
        used_next = used_reg;     head_next = head_reg;   tail_next = tail_reg;
        total_next = total_reg;   ccnt_next = ccnt_reg;   pos_next = pos_reg;
        status_next = status_reg;

        char_we = 1'b0; fc_we = 1'b0; sib_we = 1'b0; fail_we = 1'b0; cnt_we = 1'b0;
        q_we = 1'b0;
        char_wa = child_reg; fc_wa = child_reg; sib_wa = child_reg; fail_wa = child_reg;
        cnt_wa = child_reg;  q_wa = tail_reg[NB-1:0];
        char_wd = sym_reg; fc_wd = '0; sib_wd = '0; fail_wd = '0; cnt_wd = '0;
        q_wd = child_reg;
        char_ra = walk_reg; fc_ra = fnode_reg; sib_ra = walk_reg; fail_ra = fnode_reg;
        cnt_ra = cur_reg;   q_ra = head_reg[NB-1:0];

        cnt_sum = {1'b0, ccnt_reg} + {1'b0, cnt_rd};
        tot_sum = {1'b0, total_reg} + {{(TB-CB+1){1'b0}}, pos_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = item.kind;
                    sym_next = item.symbol;
                    last_next = item.last;
                    status_next = mpsm_pkg::STATUS_OK;
                    pos_next = '0;
                    case (item.kind)
                        mpsm_pkg::KIND_PATTERN:
                        begin
                            // A pattern after a build starts a new dictionary.
                            if (built_reg)
                            begin
                                used_next = (NB+1)'(1);
                                root_fc_next = '0;
                                cur_next = ROOT;
                                total_next = '0;
                                built_next = 1'b0;
                                dropped_next = 1'b0;
                            end
                            state_next = S_PSTART;
                        end
                        mpsm_pkg::KIND_BUILD:
                        begin
                            cur_next = ROOT;
                            dropped_next = 1'b0;
                            child_next = root_fc_reg;
                            head_next = '0;
                            tail_next = '0;
                            state_next = built_reg ? S_DONE : S_BROOT;
                        end
                        mpsm_pkg::KIND_TEXT:
                        begin
                            if (!built_reg)
                            begin
                                status_next = mpsm_pkg::STATUS_NOBUILD;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                fnode_next = cur_reg;
                                fsym_next = item.symbol;
                                ret_next = S_TFR;
                                state_next = S_FC0;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Pattern insertion.
            S_PSTART:
            begin
                if (sym_reg != '0 && !dropped_reg)
                begin
                    fnode_next = cur_reg;
                    fsym_next = sym_reg;
                    ret_next = S_PFOUND;
                    state_next = S_FC0;
                end
                else
                begin
                    state_next = S_PLAST;
                end
            end
            S_PFOUND:
            begin
                if (found_reg != ROOT)
                begin
                    cur_next = found_reg;
                    state_next = S_PLAST;
                end
                else if (used_reg < MAX_USED)
                begin
                    // Allocate and initialize a new node.
                    char_we = 1'b0;
                    char_wa = used_reg[NB-1:0]; fc_wa = used_reg[NB-1:0];
                    sib_wa = used_reg[NB-1:0];  fail_wa = used_reg[NB-1:0];
                    cnt_wa = used_reg[NB-1:0];
                    char_we = 1'b1; fc_we = 1'b1; sib_we = 1'b1; fail_we = 1'b1;
                    cnt_we = 1'b1;
                    child_next = used_reg[NB-1:0];
                    used_next = used_reg + 1'b1;
                    state_next = S_PLINK;
                end
                else
                begin
                    dropped_next = 1'b1;
                    state_next = S_PLAST;
                end
            end
            S_PLINK:
            begin
                // Hook the new node onto its parent or the last sibling.
                if (empty_reg)
                begin
                    if (cur_reg == ROOT)
                    begin
                        root_fc_next = child_reg;
                    end
                    else
                    begin
                        fc_we = 1'b1;
                        fc_wa = cur_reg;
                        fc_wd = child_reg;
                    end
                end
                else
                begin
                    sib_we = 1'b1;
                    sib_wa = prev_reg;
                    sib_wd = child_reg;
                end
                cur_next = child_reg;
                state_next = S_PLAST;
            end
            S_PLAST:
            begin
                status_next = dropped_reg ? mpsm_pkg::STATUS_FULL : mpsm_pkg::STATUS_OK;
                if (last_reg && !dropped_reg && cur_reg != ROOT)
                begin
                    cnt_ra = cur_reg;
                    state_next = S_PINC_W;
                end
                else
                begin
                    if (last_reg)
                    begin
                        cur_next = ROOT;
                        dropped_next = 1'b0;
                    end
                    state_next = S_DONE;
                end
            end
            S_PINC_W:
            begin
                cnt_we = 1'b1;
                cnt_wa = cur_reg;
                cnt_wd = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
                cur_next = ROOT;
                dropped_next = 1'b0;
                state_next = S_DONE;
            end

            // Failure links, first the children of the root.
            S_BROOT:
            begin
                if (child_reg == ROOT)
                begin
                    state_next = S_BDEQ;
                end
                else
                begin
                    fail_we = 1'b1;
                    fail_wa = child_reg;
                    fail_wd = ROOT;
                    q_we = 1'b1;
                    tail_next = tail_reg + 1'b1;
                    sib_ra = child_reg;
                    state_next = S_BRSIB_W;
                end
            end
            S_BRSIB_W:
            begin
                child_next = sib_rd;
                state_next = S_BROOT;
            end
            S_BDEQ:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    q_ra = head_reg[NB-1:0];
                    head_next = head_reg + 1'b1;
                    state_next = S_BDEQ_W;
                end
            end
            S_BDEQ_W:
            begin
                fc_ra = q_rd;
                fail_ra = q_rd;
                state_next = S_BU_W;
            end
            S_BU_W:
            begin
                child_next = fc_rd;
                fu_next = fail_rd;
                state_next = S_BCHILD;
            end
            S_BCHILD:
            begin
                if (child_reg == ROOT)
                begin
                    state_next = S_BDEQ;
                end
                else
                begin
                    if (tail_reg < MAX_USED)
                    begin
                        q_we = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                    char_ra = child_reg;
                    cnt_ra = child_reg;
                    state_next = S_BC_W;
                end
            end
            S_BC_W:
            begin
                ccnt_next = cnt_rd;
                fsym_next = char_rd;
                fnode_next = fu_reg;
                ret_next = S_BFR;
                state_next = S_FC0;
            end
            S_BFR:
            begin
                if (found_reg != ROOT || fnode_reg == ROOT)
                begin
                    fail_we = 1'b1;
                    fail_wa = child_reg;
                    fail_wd = found_reg;
                    cnt_ra = found_reg;
                    state_next = (found_reg == ROOT) ? S_BNEXT : S_BCNT_W;
                end
                else
                begin
                    fail_ra = fnode_reg;
                    state_next = S_BFF_W;
                end
            end
            S_BCNT_W:
            begin
                cnt_we = 1'b1;
                cnt_wa = child_reg;
                cnt_wd = cnt_sum[CB] ? '1 : cnt_sum[CB-1:0];
                state_next = S_BNEXT;
            end
            S_BFF_W:
            begin
                fnode_next = fail_rd;
                state_next = S_FC0;
            end
            S_BNEXT:
            begin
                sib_ra = child_reg;
                state_next = S_BNEXT_W;
            end
            S_BNEXT_W:
            begin
                child_next = sib_rd;
                state_next = S_BCHILD;
            end

            // Text walk.
            S_TFR:
            begin
                if (found_reg != ROOT)
                begin
                    fnode_next = found_reg;
                    state_next = S_TCNT;
                end
                else if (fnode_reg == ROOT)
                begin
                    state_next = S_TCNT;
                end
                else
                begin
                    fail_ra = fnode_reg;
                    state_next = S_TFW;
                end
            end
            S_TFW:
            begin
                fnode_next = fail_rd;
                state_next = S_FC0;
            end
            S_TCNT:
            begin
                cnt_ra = fnode_reg;
                if (fnode_reg == ROOT)
                begin
                    pos_next = '0;
                    state_next = S_TSUM;
                end
                else
                begin
                    state_next = S_TC_W;
                end
            end
            S_TC_W:
            begin
                pos_next = cnt_rd;
                state_next = S_TSUM;
            end
            S_TSUM:
            begin
                total_next = tot_sum[TB] ? '1 : tot_sum[TB-1:0];
                cur_next = fnode_reg;
                state_next = S_DONE;
            end

            // Child search: walk the sibling list of fnode for fsym.
            S_FC0:
            begin
                empty_next = 1'b1;
                found_next = ROOT;
                if (fnode_reg == ROOT)
                begin
                    walk_next = root_fc_reg;
                    state_next = S_FCCHK;
                end
                else
                begin
                    fc_ra = fnode_reg;
                    state_next = S_FC_W;
                end
            end
            S_FC_W:
            begin
                walk_next = fc_rd;
                state_next = S_FCCHK;
            end
            S_FCCHK:
            begin
                if (walk_reg == ROOT)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    empty_next = 1'b0;
                    prev_next = walk_reg;
                    char_ra = walk_reg;
                    sib_ra = walk_reg;
                    state_next = S_FCCMP;
                end
            end
            S_FCCMP:
            begin
                if (char_rd == fsym_reg)
                begin
                    found_next = walk_reg;
                    state_next = ret_reg;
                end
                else
                begin
                    walk_next = sib_rd;
                    state_next = S_FCCHK;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    if (kind_reg == mpsm_pkg::KIND_TEXT && last_reg)
                    begin
                        cur_next = ROOT;
                        total_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg <= ROOT;
            root_fc_reg <= ROOT;
            built_reg <= 1'b0;
            dropped_reg <= 1'b0;
            used_reg <= (NB+1)'(1);
            head_reg <= '0;
            tail_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg <= cur_next;
            root_fc_reg <= root_fc_next;
            built_reg <= built_next;
            dropped_reg <= dropped_next;
            used_reg <= used_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            total_reg <= total_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next;
        kind_reg <= kind_next;
        sym_reg <= sym_next;
        fsym_reg <= fsym_next;
        last_reg <= last_next;
        walk_reg <= walk_next;
        prev_reg <= prev_next;
        found_reg <= found_next;
        fnode_reg <= fnode_next;
        child_reg <= child_next;
        fu_reg <= fu_next;
        empty_reg <= empty_next;
        ccnt_reg <= ccnt_next;
        pos_reg <= pos_next;
        status_reg <= status_next;
    end

`ifndef SYNTH
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != '0 && used_reg <= MAX_USED)
        else $error("node count out of range");
    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after a result");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("item taken while busy");
`endif

endmodule

// ===== design/multi_pattern_string_matcher.sv =====
// Top level of the multi-pattern string matcher: stream ports and result register.
// Uses mpsm_pkg and mpsm_ctrl.
//
//   channel  | direction | tdata             | tuser      | tlast
//   s_axis   | in        | symbol[7:0]       | kind[1:0]  | last
//   m_axis   | out       | position_matches, | status[1:0]| text_end
//            |           | total_matches     |            |
//
// One item at a time; tready returns in the cycle after the result is handed over.
// A pattern character costs more for each sibling compared, and more again when it
// adds a new node or counts a pattern end. A text character costs more for each
// sibling compared and for each failure step. A build costs more for each node and
// its failure-chain searches. The node memories each have a single registered read
// port. Reset clears control state only; the trie memories need no clearing. A
// result waits in the output register while the next item is taken.
module multi_pattern_string_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // symbol[7:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // position_matches[15:0], total_matches[47:16]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    logic              idle, done, out_free;
    mpsm_pkg::item_t   item;
    mpsm_pkg::result_t result;
    mpsm_pkg::result_t out_reg;
    logic              out_valid_reg;

    assign item.kind = s_axis_tuser;
    assign item.symbol = s_axis_tdata;
    assign item.last = s_axis_tlast;
    assign s_axis_tready = idle;
    assign out_free = !out_valid_reg || m_axis_tready;

    mpsm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(s_axis_tvalid && idle), .item(item),
        .out_free(out_free), .idle(idle), .done(done), .result(result));

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= done;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {out_reg.total_matches, out_reg.position_matches};
    assign m_axis_tuser = out_reg.status;
    assign m_axis_tlast = out_reg.text_end;

endmodule
